// ===== design/lpcp_pkg.sv =====
package lpcp_pkg;

    localparam int PT_W    = 32;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = 48;
    localparam int CAM_W   = 50;
    localparam int MAG_W   = 49;
    localparam int F_W     = 32;
    localparam int QB      = 34;
    localparam int P_W     = 81;
    localparam int U_W     = 36;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int T_SHIFT = 22;

    localparam int XF_LAT   = 3;
    localparam int DIV_LAT  = QB + 3;
    localparam int POST_LAT = 3;
    localparam int LAT      = XF_LAT + DIV_LAT + POST_LAT;

    typedef enum logic [2:0] {
        CFG_ROT_X  = 3'd0,
        CFG_ROT_Y  = 3'd1,
        CFG_ROT_Z  = 3'd2,
        CFG_FOCAL  = 3'd3,
        CFG_PRINC  = 3'd4,
        CFG_DIMS   = 3'd5,
        CFG_STRIDE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic                 hit;
        logic [PIX_W-1:0]     pixel_col;
        logic [PIX_W-1:0]     pixel_row;
        logic [ADDR_W-1:0]    byte_address;
    } pixel_t;

    typedef struct packed {
        logic             pos;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } div_in_t;

    typedef struct packed {
        logic          pos;
        logic          neg;
        logic          ovf;
        logic          rem_nz;
        logic [QB-1:0] quot;
    } div_res_t;

endpackage

// ===== design/lpcp_xform.sv =====
module lpcp_xform (
    input  logic                     clk,
    input  logic                     adv,
    input  lpcp_pkg::point_t         pt,
    input  logic [63:0]              row_x,
    input  logic [63:0]              row_y,
    input  logic [63:0]              row_z,
    output lpcp_pkg::div_in_t        num_x,
    output lpcp_pkg::div_in_t        num_y,
    output logic [lpcp_pkg::MAG_W-1:0] den
);
    import lpcp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [CAM_W-1:0]  cam_reg  [3];
    logic signed [CAM_W-1:0]  cam_next [3];
    logic [63:0]              rows [3];
    logic signed [PT_W-1:0]   pv [3];
    div_in_t                  nx_reg, ny_reg;
    logic [MAG_W-1:0]         den_reg;

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_z;
    assign pv[0]   = pt.point_x;
    assign pv[1]   = pt.point_y;
    assign pv[2]   = pt.point_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cam_next[a] = CAM_W'(prod_reg[a][0]) + CAM_W'(prod_reg[a][1])
                        + CAM_W'(prod_reg[a][2])
                        + (CAM_W'(signed'(rows[a][63:48])) <<< T_SHIFT);
        end
    end

    function automatic div_in_t to_num(input logic signed [CAM_W-1:0] v, input logic p);
        div_in_t r;
        r.pos = p;
        r.neg = v[CAM_W-1];
        r.mag = v[CAM_W-1] ? MAG_W'(-v) : v[MAG_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    prod_reg[a][b] <= PROD_W'(signed'(rows[a][16*b +: 16])) * PROD_W'(pv[b]);
                end
                cam_reg[a] <= cam_next[a];
            end
            nx_reg  <= to_num(cam_reg[0], cam_reg[2] > 0);
            ny_reg  <= to_num(cam_reg[1], cam_reg[2] > 0);
            den_reg <= cam_reg[2][MAG_W-1:0];
        end
    end

    assign num_x = nx_reg;
    assign num_y = ny_reg;
    assign den   = den_reg;

endmodule

// ===== design/lpcp_div.sv =====
module lpcp_div (
    input  logic                       clk,
    input  logic                       adv,
    input  lpcp_pkg::div_in_t          din,
    input  logic [lpcp_pkg::MAG_W-1:0] den,
    input  logic [lpcp_pkg::F_W-1:0]   fcoef,
    output lpcp_pkg::div_res_t         res
);
    import lpcp_pkg::*;

    localparam int HI_W = MAG_W - 32;

    logic [63:0]           plo_reg;
    logic [HI_W+F_W-1:0]   phi_reg;
    logic [MAG_W-1:0]      den_a_reg, den_b_reg;
    div_in_t               tag_a_reg, tag_b_reg;
    logic [P_W-1:0]        prod_reg;

    logic [MAG_W-1:0]      rem_reg  [QB+1];
    logic [QB-1:0]         x_reg    [QB+1];
    logic [MAG_W-1:0]      dv_reg   [QB+1];
    logic                  pos_reg  [QB+1];
    logic                  neg_reg  [QB+1];
    logic                  ovf_reg  [QB+1];

    logic [MAG_W:0]        trial [QB+1];
    logic                  take  [QB+1];
    logic [MAG_W:0]        diff  [QB+1];

    always_comb
    begin
        trial[0] = '0;
        take[0]  = 1'b0;
        diff[0]  = '0;
        for (int k = 1; k <= QB; k++)
        begin
            trial[k] = {rem_reg[k-1], x_reg[k-1][QB-1]};
            take[k]  = trial[k] >= {1'b0, dv_reg[k-1]};
            diff[k]  = trial[k] - {1'b0, dv_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // split the wide product into two partial products
            plo_reg   <= 64'(din.mag[31:0]) * 64'(fcoef);
            phi_reg   <= (HI_W+F_W)'(din.mag[MAG_W-1:32]) * (HI_W+F_W)'(fcoef);
            den_a_reg <= den;
            tag_a_reg <= din;

            prod_reg  <= {phi_reg, 32'b0} + P_W'(plo_reg);
            den_b_reg <= den_a_reg;
            tag_b_reg <= tag_a_reg;

            // quotient of 2^QB or more can never land in the image
            ovf_reg[0] <= {2'b0, prod_reg[P_W-1:QB]} >= den_b_reg;
            rem_reg[0] <= {2'b0, prod_reg[P_W-1:QB]};
            x_reg[0]   <= prod_reg[QB-1:0];
            dv_reg[0]  <= den_b_reg;
            pos_reg[0] <= tag_b_reg.pos;
            neg_reg[0] <= tag_b_reg.neg;

            for (int k = 1; k <= QB; k++)
            begin
                rem_reg[k] <= take[k] ? diff[k][MAG_W-1:0] : trial[k][MAG_W-1:0];
                x_reg[k]   <= {x_reg[k-1][QB-2:0], take[k]};
                dv_reg[k]  <= dv_reg[k-1];
                pos_reg[k] <= pos_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign res.pos    = pos_reg[QB];
    assign res.neg    = neg_reg[QB];
    assign res.ovf    = ovf_reg[QB];
    assign res.rem_nz = |rem_reg[QB];
    assign res.quot   = x_reg[QB];

endmodule

// ===== design/lpcp_addr.sv =====
module lpcp_addr #(
    parameter int BYTES_PER_PIXEL = 3
) (
    input  logic                clk,
    input  logic                adv,
    input  lpcp_pkg::div_res_t  res_u,
    input  lpcp_pkg::div_res_t  res_v,
    input  logic [31:0]         cx,
    input  logic [31:0]         cy,
    input  logic [15:0]         img_w,
    input  logic [15:0]         img_h,
    input  logic [15:0]         stride,
    output lpcp_pkg::pixel_t    pix
);
    import lpcp_pkg::*;

    localparam int BPP_W = $clog2(BYTES_PER_PIXEL + 1);
    localparam int CM_W  = PIX_W + BPP_W;

    logic signed [U_W-1:0] u, v;
    logic                  in_u, in_v;
    logic                  hit_a_reg, hit_b_reg;
    logic [PIX_W-1:0]      col_a_reg, row_a_reg, col_b_reg, row_b_reg;
    logic [ADDR_W-1:0]     rm_reg;
    logic [CM_W-1:0]       cm_reg;
    logic [ADDR_W:0]       sum;
    pixel_t                pix_reg;

    function automatic logic signed [U_W-1:0] fix_coord(input div_res_t r,
                                                         input logic [31:0] c);
        logic signed [U_W-1:0] s;
        if (r.neg)
            s = U_W'(c) - U_W'(r.quot) - U_W'(r.rem_nz);
        else
            s = U_W'(c) + U_W'(r.quot);
        return s;
    endfunction

    always_comb
    begin
        u    = fix_coord(res_u, cx);
        v    = fix_coord(res_v, cy);
        in_u = !u[U_W-1] && (u[U_W-2:0] < (U_W-1)'({img_w, 16'b0}));
        in_v = !v[U_W-1] && (v[U_W-2:0] < (U_W-1)'({img_h, 16'b0}));
        sum  = (ADDR_W+1)'(rm_reg) + (ADDR_W+1)'(cm_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_a_reg <= res_u.pos && !res_u.ovf && !res_v.ovf && in_u && in_v;
            col_a_reg <= u[31:16];
            row_a_reg <= v[31:16];

            rm_reg    <= ADDR_W'(row_a_reg) * ADDR_W'(stride);
            cm_reg    <= CM_W'(col_a_reg) * CM_W'(BYTES_PER_PIXEL);
            hit_b_reg <= hit_a_reg;
            col_b_reg <= col_a_reg;
            row_b_reg <= row_a_reg;

            // address past 32 bits gives no hit
            if (hit_b_reg && !sum[ADDR_W])
            begin
                pix_reg.hit          <= 1'b1;
                pix_reg.pixel_col    <= col_b_reg;
                pix_reg.pixel_row    <= row_b_reg;
                pix_reg.byte_address <= sum[ADDR_W-1:0];
            end
            else
            begin
                pix_reg <= '0;
            end
        end
    end

    assign pix = pix_reg;

endmodule

// ===== design/lidar_point_camera_projection.sv =====
// lidar point to camera pixel projection, one camera, pinhole model
// in channel: in_valid/in_ready with in_data carrying point_x/y/z (signed Q15.16)
// out channel: out_valid/out_ready with out_data holding hit, pixel column/row
// and the byte address of the pixel's first color byte; misses report zeros
// cfg channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// only while no request is in flight; indexes past row_stride are ignored
// one request per cycle sustained while the output does not stall; a request passes the 34
// one-bit steps of the projection divider, one per pipeline stage, after 3
// transform and 3 multiply stages and before 3 address stages
// reset: configuration and valid registers clear to zero and the pipeline empties
// stall: when a result waits with out_ready low the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated
module lidar_point_camera_projection #(
    parameter int BYTES_PER_PIXEL = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lpcp_pkg::point_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lpcp_pkg::pixel_t  out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import lpcp_pkg::*;

    logic [63:0]     rot_x_reg, rot_y_reg, rot_z_reg, focal_reg, princ_reg;
    logic [31:0]     dims_reg;
    logic [15:0]     stride_reg;
    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vld_next;
    logic            adv;
    div_in_t         num_x, num_y;
    logic [MAG_W-1:0] den;
    div_res_t        res_u, res_v;
    pixel_t          pix;

    assign adv       = !(vld_reg[LAT-1] && !out_ready);
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[LAT-1];
    assign out_data  = pix;
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg  <= '0;
            rot_y_reg  <= '0;
            rot_z_reg  <= '0;
            focal_reg  <= '0;
            princ_reg  <= '0;
            dims_reg   <= '0;
            stride_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROT_X:  rot_x_reg  <= cfg_data;
                CFG_ROT_Y:  rot_y_reg  <= cfg_data;
                CFG_ROT_Z:  rot_z_reg  <= cfg_data;
                CFG_FOCAL:  focal_reg  <= cfg_data;
                CFG_PRINC:  princ_reg  <= cfg_data;
                CFG_DIMS:   dims_reg   <= cfg_data[31:0];
                CFG_STRIDE: stride_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    lpcp_xform u_xform (
        .clk   (clk),
        .adv   (adv),
        .pt    (in_data),
        .row_x (rot_x_reg),
        .row_y (rot_y_reg),
        .row_z (rot_z_reg),
        .num_x (num_x),
        .num_y (num_y),
        .den   (den)
    );

    lpcp_div u_div_u (
        .clk   (clk),
        .adv   (adv),
        .din   (num_x),
        .den   (den),
        .fcoef (focal_reg[31:0]),
        .res   (res_u)
    );

    lpcp_div u_div_v (
        .clk   (clk),
        .adv   (adv),
        .din   (num_y),
        .den   (den),
        .fcoef (focal_reg[63:32]),
        .res   (res_v)
    );

    lpcp_addr #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_addr (
        .clk    (clk),
        .adv    (adv),
        .res_u  (res_u),
        .res_v  (res_v),
        .cx     (princ_reg[31:0]),
        .cy     (princ_reg[63:32]),
        .img_w  (dims_reg[15:0]),
        .img_h  (dims_reg[31:16]),
        .stride (stride_reg),
        .pix    (pix)
    );

`ifndef NO_ASSERTIONS
    a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |->
            out_data.pixel_col < dims_reg[15:0] && out_data.pixel_row < dims_reg[31:16])
        else $error("hit outside image");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |->
            out_data.pixel_col == '0 && out_data.pixel_row == '0
            && out_data.byte_address == '0)
        else $error("miss with nonzero fields");

    a_addr_math: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |->
            out_data.byte_address == ADDR_W'(ADDR_W'(out_data.pixel_row) * ADDR_W'(stride_reg)
                + ADDR_W'(out_data.pixel_col) * ADDR_W'(BYTES_PER_PIXEL)))
        else $error("byte address mismatch");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[0]) |-> $past(in_valid && in_ready))
        else $error("pipeline valid without request");
`endif

endmodule
